// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iougt_pkg.sv =====
// ----------------------------------------------------------------------------
// iougt_pkg
// Constants and codes for the greedy IoU box tracker.
// ----------------------------------------------------------------------------
package iougt_pkg;

    localparam int MAX_TRACKS_DEF     = 32;
    localparam int MAX_DETECTIONS_DEF = 32;
    localparam int COORD_BITS_DEF     = 12;

    localparam int ID_BITS    = 32;
    localparam int AGE_BITS   = 9;
    localparam int CLASS_BITS = 16;
    localparam int SCORE_BITS = 16;
    localparam int IOU_BITS   = 17;
    localparam int IOU_CNT_BITS = $clog2(IOU_BITS);

    localparam int MIN_IOU_BITS = 16;
    localparam int MAX_AGE_BITS = 8;
    localparam logic [MIN_IOU_BITS-1:0] MIN_IOU_RESET = 16'd19661;
    localparam logic [MAX_AGE_BITS-1:0] MAX_AGE_RESET = 8'd30;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_IOU = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_AGE = 8'd1;

    localparam logic [1:0] FUNC_DET   = 2'd0;
    localparam logic [1:0] FUNC_EMPTY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

endpackage

// ===== rtl/iou_greedy_box_tracker_core.sv =====
// ----------------------------------------------------------------------------
// iou_greedy_box_tracker_core
// Frame-based box tracker: greedy IoU association of detections to tracks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready): one beat per detection (func 0),
//   frame_last on the last one closes the frame; func 1 closes an empty frame,
//   func 2 clears the tracker. Input is taken only while the sequencer idles.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; write it idle.
//   Output channel (o_out_valid/i_out_ready): one beat per surviving track in
//   table order, run_last on the last; a lone marker beat if none survive.
// Sequence, nd detections and nt old tracks, m matches:
//   IoU pass: one IoU per pair, nd*nt pairs (one shared multiplier, then a
//   17-step restoring divider). Greedy pass: (m+1) scans over the IoU memory,
//   each match then written into its track. New tracks, aging/compaction and
//   output follow, the output one beat per surviving track.
//   A detection beat without frame_last keeps the sequencer idle.
// Reset: track and detection counts and next id cleared, config registers to defaults.
// A stalled receiver holds the output register and the emit sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iou_greedy_box_tracker_core #(
    parameter int MAX_TRACKS     = iougt_pkg::MAX_TRACKS_DEF,
    parameter int MAX_DETECTIONS = iougt_pkg::MAX_DETECTIONS_DEF,
    parameter int COORD_BITS     = iougt_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [iougt_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [iougt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // detections
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_func,
    input  logic [COORD_BITS-1:0]                i_box_x,
    input  logic [COORD_BITS-1:0]                i_box_y,
    input  logic [COORD_BITS-1:0]                i_box_width,
    input  logic [COORD_BITS-1:0]                i_box_height,
    input  logic [iougt_pkg::CLASS_BITS-1:0]     i_class_code,
    input  logic [iougt_pkg::SCORE_BITS-1:0]     i_score,
    input  logic                                 i_frame_last,
    // tracks
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_track_valid,
    output logic [iougt_pkg::ID_BITS-1:0]        o_track_id,
    output logic [COORD_BITS-1:0]                o_out_x,
    output logic [COORD_BITS-1:0]                o_out_y,
    output logic [COORD_BITS-1:0]                o_out_width,
    output logic [COORD_BITS-1:0]                o_out_height,
    output logic [iougt_pkg::CLASS_BITS-1:0]     o_out_class,
    output logic [iougt_pkg::SCORE_BITS-1:0]     o_out_score,
    output logic [iougt_pkg::AGE_BITS-1:0]       o_track_age,
    output logic                                 o_dropped,
    output logic                                 o_run_last
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CW   = $clog2(MAX_DETECTIONS + 1);
    localparam int TW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCW  = $clog2(MAX_TRACKS + 1);
    localparam int AB   = iougt_pkg::AGE_BITS;
    localparam int IB   = iougt_pkg::ID_BITS;
    localparam int QB   = iougt_pkg::IOU_BITS;
    localparam int LOWW = iougt_pkg::CLASS_BITS + iougt_pkg::SCORE_BITS;
    localparam int BOXW = 4 * CB + LOWW;
    localparam int TRKW = IB + BOXW + AB;
    localparam int OFS_X = LOWW + 3 * CB;
    localparam int OFS_Y = LOWW + 2 * CB;
    localparam int OFS_W = LOWW + CB;
    localparam int OFS_H = LOWW;
    localparam int PW   = 2 * CB;
    localparam int UW   = 2 * CB + 1;
    localparam int RW   = 2 * CB + 2;
    localparam int IOU_DEPTH = 1 << (DW + TW);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_PR, S_POV, S_MUL_I, S_MUL_A, S_MUL_B, S_UNI, S_DIV,
        S_PWR, S_GINIT, S_GRD, S_GEV, S_URD, S_UWR, S_NRD, S_NWR, S_ARD, S_AWR,
        S_ERD, S_ELD
    } t_state;

    t_state r_state;

    logic [iougt_pkg::MIN_IOU_BITS-1:0] r_min_iou;
    logic [iougt_pkg::MAX_AGE_BITS-1:0] r_max_age;
    logic [CW-1:0]   r_dcnt;
    logic [TCW-1:0]  r_tcnt;
    logic [TCW-1:0]  r_nt;
    logic [IB-1:0]   r_next_id;
    logic [MAX_DETECTIONS-1:0] r_det_taken;
    logic [MAX_TRACKS-1:0]     r_trk_taken;
    logic            r_dropped;
    logic [CW-1:0]   r_i;
    logic [TCW-1:0]  r_j;
    logic [TCW-1:0]  r_k;
    logic [CB-1:0]   r_ox;
    logic [CB-1:0]   r_oy;
    logic [PW-1:0]   r_inter;
    logic [PW-1:0]   r_area_a;
    logic [PW-1:0]   r_area_b;
    logic [UW-1:0]   r_uni;
    logic [RW-1:0]   r_rem;
    logic [QB-1:0]   r_q;
    logic [iougt_pkg::IOU_CNT_BITS-1:0] r_bit_cnt;
    logic            r_found;
    logic [QB-1:0]   r_best;
    logic [DW-1:0]   r_bi;
    logic [TW-1:0]   r_bj;

    logic            r_out_valid;
    logic            r_o_tvalid;
    logic [IB-1:0]   r_o_id;
    logic [BOXW-1:0] r_o_box;
    logic [AB-1:0]   r_o_age;
    logic            r_o_dropped;
    logic            r_o_last;

    // memories
    logic [BOXW-1:0] m_det [0:MAX_DETECTIONS-1];
    logic [TRKW-1:0] m_trk [0:MAX_TRACKS-1];
    logic [QB:0]     m_iou [0:IOU_DEPTH-1];
    logic [BOXW-1:0] r_det_rd;
    logic [TRKW-1:0] r_trk_rd;
    logic [QB:0]     r_iou_rd;

    logic            det_we, det_re, trk_we, trk_re, iou_we, iou_re;
    logic [DW-1:0]   det_waddr, det_raddr;
    logic [TW-1:0]   trk_waddr, trk_raddr;
    logic [BOXW-1:0] det_wdata;
    logic [TRKW-1:0] trk_wdata;
    logic [DW+TW-1:0] iou_addr;
    logic [QB:0]     iou_wdata;

    logic            w_in_acc;
    logic            w_out_free;
    logic            w_out_load;
    logic [DW-1:0]   w_i;
    logic [TW-1:0]   w_j;
    logic [CW-1:0]   w_i_inc;
    logic [TCW-1:0]  w_j_inc;
    logic [CB-1:0]   w_mul_a, w_mul_b;
    logic [PW-1:0]   w_prod;
    logic            w_rem_ge;
    logic [QB-1:0]   w_iou_q;
    logic            w_take;
    logic [AB-1:0]   w_aged;
    logic            w_keep;
    logic [IB-1:0]   w_t_id;
    logic [BOXW-1:0] w_t_box;
    logic [AB-1:0]   w_t_age;

    function automatic logic [CB-1:0] f_overlap(input logic [CB-1:0] a0,
                                                input logic [CB-1:0] aw,
                                                input logic [CB-1:0] b0,
                                                input logic [CB-1:0] bw);
        logic [CB:0] ae;
        logic [CB:0] be;
        logic [CB:0] lo;
        logic [CB:0] hi;
        ae = {1'b0, a0} + {1'b0, aw};
        be = {1'b0, b0} + {1'b0, bw};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (ae < be) ? ae : be;
        f_overlap = (hi > lo) ? CB'(hi - lo) : '0;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = w_out_free && (((r_state == S_ERD) && (r_tcnt == '0))
                                        || (r_state == S_ELD));

    assign w_i     = r_i[DW-1:0];
    assign w_j     = r_j[TW-1:0];
    assign w_i_inc = r_i + CW'(1);
    assign w_j_inc = r_j + TCW'(1);

    assign w_t_id  = r_trk_rd[AB+BOXW +: IB];
    assign w_t_box = r_trk_rd[AB +: BOXW];
    assign w_t_age = r_trk_rd[AB-1:0];

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MUL_I: begin
                w_mul_a = r_ox;
                w_mul_b = r_oy;
            end
            S_MUL_A: begin
                w_mul_a = r_det_rd[OFS_W +: CB];
                w_mul_b = r_det_rd[OFS_H +: CB];
            end
            default: begin
                w_mul_a = w_t_box[OFS_W +: CB];
                w_mul_b = w_t_box[OFS_H +: CB];
            end
        endcase
    end
    assign w_prod = {{CB{1'b0}}, w_mul_a} * {{CB{1'b0}}, w_mul_b};

    assign w_rem_ge = (r_rem >= {1'b0, r_uni});
    assign w_iou_q  = (r_uni == '0) ? '0 : r_q;

    assign w_take = !r_det_taken[w_i] && !r_trk_taken[w_j] && r_iou_rd[QB]
                    && (!r_found || (r_iou_rd[QB-1:0] > r_best));

    assign w_aged = ((r_j < r_nt) && !r_trk_taken[w_j]) ? (w_t_age + AB'(1)) : w_t_age;
    assign w_keep = (w_aged <= {1'b0, r_max_age});

    // memory port control
    always_comb begin
        det_we    = 1'b0;
        det_re    = 1'b0;
        det_waddr = r_dcnt[DW-1:0];
        det_raddr = w_i;
        det_wdata = {i_box_x, i_box_y, i_box_width, i_box_height, i_class_code, i_score};
        trk_we    = 1'b0;
        trk_re    = 1'b0;
        trk_waddr = r_bj;
        trk_raddr = w_j;
        trk_wdata = {w_t_id, r_det_rd, {AB{1'b0}}};
        iou_we    = 1'b0;
        iou_re    = 1'b0;
        iou_addr  = {w_i, w_j};
        iou_wdata = {(w_iou_q > {1'b0, r_min_iou}), w_iou_q};
        case (r_state)
            S_IDLE: begin
                det_we = w_in_acc && (i_func == iougt_pkg::FUNC_DET)
                         && (r_dcnt != CW'(MAX_DETECTIONS));
            end
            S_PR: begin
                det_re = 1'b1;
                trk_re = 1'b1;
            end
            S_PWR: iou_we = 1'b1;
            S_GRD: iou_re = 1'b1;
            S_URD: begin
                det_re    = 1'b1;
                det_raddr = r_bi;
                trk_re    = 1'b1;
                trk_raddr = r_bj;
            end
            S_UWR: trk_we = 1'b1;
            S_NRD: begin
                det_re = (r_i != r_dcnt) && !r_det_taken[w_i]
                         && (r_tcnt != TCW'(MAX_TRACKS));
            end
            S_NWR: begin
                trk_we    = 1'b1;
                trk_waddr = r_tcnt[TW-1:0];
                trk_wdata = {r_next_id, r_det_rd, {AB{1'b0}}};
            end
            S_ARD: trk_re = (r_j != r_tcnt);
            S_AWR: begin
                trk_we    = w_keep;
                trk_waddr = r_k[TW-1:0];
                trk_wdata = {w_t_id, w_t_box, w_aged};
            end
            S_ERD: trk_re = (r_tcnt != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (det_we) begin
            m_det[det_waddr] <= det_wdata;
        end
        if (det_re) begin
            r_det_rd <= m_det[det_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (trk_we) begin
            m_trk[trk_waddr] <= trk_wdata;
        end
        if (trk_re) begin
            r_trk_rd <= m_trk[trk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (iou_we) begin
            m_iou[iou_addr] <= iou_wdata;
        end
        if (iou_re) begin
            r_iou_rd <= m_iou[iou_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_iou   <= iougt_pkg::MIN_IOU_RESET;
            r_max_age   <= iougt_pkg::MAX_AGE_RESET;
            r_dcnt      <= '0;
            r_tcnt      <= '0;
            r_nt        <= '0;
            r_next_id   <= '0;
            r_det_taken <= '0;
            r_trk_taken <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    iougt_pkg::CFG_MIN_IOU: r_min_iou <= i_cfg_data;
                    iougt_pkg::CFG_MAX_AGE: r_max_age <= i_cfg_data[iougt_pkg::MAX_AGE_BITS-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_func)
                            iougt_pkg::FUNC_DET: begin
                                if (r_dcnt != CW'(MAX_DETECTIONS)) begin
                                    r_dcnt <= r_dcnt + CW'(1);
                                end
                                if (i_frame_last) begin
                                    r_state <= S_START;
                                end
                            end
                            iougt_pkg::FUNC_EMPTY: r_state <= S_START;
                            iougt_pkg::FUNC_CLEAR: begin
                                r_tcnt    <= '0;
                                r_dcnt    <= '0;
                                r_next_id <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_START: begin
                    r_det_taken <= '0;
                    r_trk_taken <= '0;
                    r_dropped   <= 1'b0;
                    r_nt        <= r_tcnt;
                    r_i         <= '0;
                    r_j         <= '0;
                    if ((r_dcnt == '0) || (r_tcnt == '0)) begin
                        r_state <= S_NRD;
                    end else begin
                        r_state <= S_PR;
                    end
                end
                S_PR: r_state <= S_POV;
                S_POV: begin
                    r_ox <= f_overlap(r_det_rd[OFS_X +: CB], r_det_rd[OFS_W +: CB],
                                      w_t_box[OFS_X +: CB], w_t_box[OFS_W +: CB]);
                    r_oy <= f_overlap(r_det_rd[OFS_Y +: CB], r_det_rd[OFS_H +: CB],
                                      w_t_box[OFS_Y +: CB], w_t_box[OFS_H +: CB]);
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_inter <= w_prod;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    r_area_a <= w_prod;
                    r_state  <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_area_b <= w_prod;
                    r_state  <= S_UNI;
                end
                S_UNI: begin
                    r_uni     <= {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
                    r_rem     <= {2'b00, r_inter};
                    r_q       <= '0;
                    r_bit_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle, MSB first
                    if (w_rem_ge) begin
                        r_q   <= {r_q[QB-2:0], 1'b1};
                        r_rem <= (r_rem - {1'b0, r_uni}) << 1;
                    end else begin
                        r_q   <= {r_q[QB-2:0], 1'b0};
                        r_rem <= r_rem << 1;
                    end
                    r_bit_cnt <= r_bit_cnt + iougt_pkg::IOU_CNT_BITS'(1);
                    if (r_bit_cnt == iougt_pkg::IOU_CNT_BITS'(QB - 1)) begin
                        r_state <= S_PWR;
                    end
                end
                S_PWR: begin
                    if (w_j_inc == r_nt) begin
                        r_j <= '0;
                        if (w_i_inc == r_dcnt) begin
                            r_state <= S_GINIT;
                        end else begin
                            r_i     <= w_i_inc;
                            r_state <= S_PR;
                        end
                    end else begin
                        r_j     <= w_j_inc;
                        r_state <= S_PR;
                    end
                end
                S_GINIT: begin
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_state <= S_GRD;
                end
                S_GRD: r_state <= S_GEV;
                S_GEV: begin
                    if (w_take) begin
                        r_found <= 1'b1;
                        r_best  <= r_iou_rd[QB-1:0];
                        r_bi    <= w_i;
                        r_bj    <= w_j;
                    end
                    if (w_j_inc == r_nt) begin
                        r_j <= '0;
                        if (w_i_inc == r_dcnt) begin
                            r_i <= '0;
                            if (r_found || w_take) begin
                                r_state <= S_URD;
                            end else begin
                                r_state <= S_NRD;
                            end
                        end else begin
                            r_i     <= w_i_inc;
                            r_state <= S_GRD;
                        end
                    end else begin
                        r_j     <= w_j_inc;
                        r_state <= S_GRD;
                    end
                end
                S_URD: begin
                    r_det_taken[r_bi] <= 1'b1;
                    r_trk_taken[r_bj] <= 1'b1;
                    r_state           <= S_UWR;
                end
                S_UWR: r_state <= S_GINIT;
                S_NRD: begin
                    if (r_i == r_dcnt) begin
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ARD;
                    end else if (r_det_taken[w_i]) begin
                        r_i <= w_i_inc;
                    end else if (r_tcnt == TCW'(MAX_TRACKS)) begin
                        // table full: drop and flag
                        r_dropped <= 1'b1;
                        r_i       <= w_i_inc;
                    end else begin
                        r_state <= S_NWR;
                    end
                end
                S_NWR: begin
                    r_tcnt    <= r_tcnt + TCW'(1);
                    r_next_id <= r_next_id + IB'(1);
                    r_i       <= w_i_inc;
                    r_state   <= S_NRD;
                end
                S_ARD: begin
                    if (r_j == r_tcnt) begin
                        r_tcnt  <= r_k;
                        r_dcnt  <= '0;
                        r_j     <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_AWR;
                    end
                end
                S_AWR: begin
                    if (w_keep) begin
                        r_k <= r_k + TCW'(1);
                    end
                    r_j     <= w_j_inc;
                    r_state <= S_ARD;
                end
                S_ERD: begin
                    if (r_tcnt != '0) begin
                        r_state <= S_ELD;
                    end else if (w_out_free) begin
                        // no survivors: frame marker beat
                        r_o_tvalid  <= 1'b0;
                        r_o_id      <= '0;
                        r_o_box     <= '0;
                        r_o_age     <= '0;
                        r_o_dropped <= r_dropped;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_ELD: begin
                    if (w_out_free) begin
                        r_o_tvalid  <= 1'b1;
                        r_o_id      <= w_t_id;
                        r_o_box     <= w_t_box;
                        r_o_age     <= w_t_age;
                        r_o_dropped <= r_dropped;
                        r_o_last    <= (w_j_inc == r_tcnt);
                        r_j         <= w_j_inc;
                        if (w_j_inc == r_tcnt) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_track_valid = r_o_tvalid;
    assign o_track_id    = r_o_id;
    assign o_out_x       = r_o_box[OFS_X +: CB];
    assign o_out_y       = r_o_box[OFS_Y +: CB];
    assign o_out_width   = r_o_box[OFS_W +: CB];
    assign o_out_height  = r_o_box[OFS_H +: CB];
    assign o_out_class   = r_o_box[iougt_pkg::SCORE_BITS +: iougt_pkg::CLASS_BITS];
    assign o_out_score   = r_o_box[0 +: iougt_pkg::SCORE_BITS];
    assign o_track_age   = r_o_age;
    assign o_dropped     = r_o_dropped;
    assign o_run_last    = r_o_last;

    `ASSERT_ALWAYS(a_tcnt_bound, i_clk, i_rst_n, r_tcnt <= TCW'(MAX_TRACKS), "track count overflow")
    `ASSERT_ALWAYS(a_dcnt_bound, i_clk, i_rst_n, r_dcnt <= CW'(MAX_DETECTIONS), "detection count overflow")
    `ASSERT_IMPLIES(a_div_rem, i_clk, i_rst_n, (r_state == S_DIV) && (r_uni != '0), (r_rem < {r_uni, 1'b0}), "divider remainder out of range")
    `ASSERT_IMPLIES(a_compact_order, i_clk, i_rst_n, (r_state == S_ARD) || (r_state == S_AWR), r_k <= r_j, "compaction write passed read")

endmodule
